// ===== rtl/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/hufd_pkg.sv =====
`default_nettype none
package hufd_pkg;

    localparam logic [1:0] KIND_SYMBOL = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef enum logic [2:0] {
        PH_TREE_NODE,
        PH_TREE_SYM,
        PH_HEADER,
        PH_COUNT,
        PH_DECODE,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_BIT,
        CTL_POP,
        CTL_DEC_WAIT,
        CTL_EMIT_DONE,
        CTL_END,
        CTL_FLUSH
    } ctl_t;

    typedef struct packed {
        logic        leaf;
        logic [2:0]  len;
        logic [31:0] data;
    } node_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [2:0]  length;
        logic [12:0] rep;
    } result_t;

    function automatic logic is_cont(input logic [7:0] x);
        return x[7:6] == 2'b10;
    endfunction

    function automatic logic [31:0] sym_align(input logic [31:0] s, input logic [2:0] len);
        logic [31:0] v;
        case (len)
            3'd1:    v = {s[7:0], 24'd0};
            3'd2:    v = {s[15:0], 16'd0};
            3'd3:    v = {s[23:0], 8'd0};
            default: v = s;
        endcase
        return v;
    endfunction

    function automatic logic sym_ok(input logic [31:0] v, input logic [2:0] len);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       ok;
        b0 = v[31:24];
        b1 = v[23:16];
        b2 = v[15:8];
        b3 = v[7:0];
        case (len)
            3'd1: ok = !b0[7];
            3'd2: ok = is_cont(b1);
            3'd3:
            begin
                ok = is_cont(b1) && is_cont(b2);
                if (b0 == 8'hE0 && (b1 < 8'hA0 || b1 > 8'hBF))
                begin
                    ok = 1'b0;
                end
                if (b0 == 8'hED && (b1 < 8'h80 || b1 > 8'h9F))
                begin
                    ok = 1'b0;
                end
            end
            default:
            begin
                ok = is_cont(b1) && is_cont(b2) && is_cont(b3);
                if (b0 == 8'hF0 && (b1 < 8'h90 || b1 > 8'hBF))
                begin
                    ok = 1'b0;
                end
                if (b0 == 8'hF4 && (b1 < 8'h80 || b1 > 8'h8F))
                begin
                    ok = 1'b0;
                end
            end
        endcase
        return ok;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/hufd_stream_if.sv =====
`default_nettype none
interface hufd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_byte;
    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface hufd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] symbol_value;
    logic [2:0]  symbol_length;
    logic [12:0] repeat_count;
    logic        last_of_item;
    modport source (output valid, output kind, output symbol_value, output symbol_length,
                    output repeat_count, output last_of_item, input ready);
    modport sink (input valid, input kind, input symbol_value, input symbol_length,
                  input repeat_count, input last_of_item, output ready);
endinterface
`default_nettype wire

// ===== rtl/hufd_ram.sv =====
`default_nettype none
module hufd_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/huffman_utf8_stream_decoder.sv =====
// Huffman decoder for UTF-8 text with a preorder-serialized code tree. Bytes
// are taken MSB first, one at a time, and the input is not ready again until
// the byte is fully decoded. A byte is accepted, then each tree, header or count
// bit is handled in turn; a closing leaf adds a pop of the stack memory, and a
// decode bit adds a wait for the node memory read. Then the end of the byte is
// checked and its last result handed over. A done result after a symbol or an
// error result at the end of a final byte adds a step, and a stalled output
// adds its stall. Results pass through a one-entry hold stage so the last
// result of a byte can be marked, then an output register. After a done or
// error result every byte is accepted and dropped until reset.
`default_nettype none
`include "assert_macros.svh"
module huffman_utf8_stream_decoder
    import hufd_pkg::*;
#(
    parameter int MAX_NODES   = 2048,
    parameter int STACK_DEPTH = 256,
    parameter int BIG_CHUNK   = 4096,
    parameter int COUNT_BITS  = 12
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hufd_in_if.sink     in_ch,
    hufd_out_if.source  out_ch
);

    localparam int AW     = $clog2(MAX_NODES);
    localparam int NCW    = $clog2(MAX_NODES + 1);
    localparam int SW     = $clog2(STACK_DEPTH);
    localparam int SPW    = $clog2(STACK_DEPTH + 1);
    localparam int CNTMAX = (1 << COUNT_BITS) - 1;
    localparam int CHMAX  = (BIG_CHUNK > CNTMAX) ? BIG_CHUNK : CNTMAX;
    localparam int CHW    = $clog2(CHMAX + 1);
    localparam int HW     = $clog2(COUNT_BITS + 1);
    localparam logic [12:0] BIG_REP = 13'(BIG_CHUNK);

    ctl_t                  ctl_reg, ctl_next;
    phase_t                phase_reg, phase_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  fin_reg, fin_next;
    logic [3:0]            left_reg, left_next;
    logic [NCW-1:0]        count_reg, count_next;
    logic [SPW-1:0]        sp_reg, sp_next;
    logic [NCW-1:0]        cur_idx_reg, cur_idx_next;
    node_t                 cur_reg, cur_next;
    node_t                 root_reg, root_next;
    logic [31:0]           shift_reg, shift_next;
    logic [5:0]            bits_reg, bits_next;
    logic [2:0]            len_reg, len_next;
    logic [CHW-1:0]        chunk_reg, chunk_next;
    logic [COUNT_BITS-1:0] acc_reg, acc_next;
    logic [HW-1:0]         hdr_reg, hdr_next;
    logic                  small_reg, small_next;
    logic                  pend_valid_reg, pend_valid_next;
    result_t               pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;
    logic                  out_last_reg, out_last_next;

    logic          nw_en, nr_en, sw_en, sr_en;
    logic [AW-1:0] nw_addr, nr_addr;
    node_t         nw_data, nr_data;
    logic [SW-1:0] sw_addr, sr_addr;
    logic [AW-1:0] sw_data, sr_data;
    logic          emit, emit_ok, out_free, terminal, in_ready;
    result_t       emit_res;

    hufd_ram #(.DEPTH(MAX_NODES), .WIDTH($bits(node_t))) u_node_ram (
        .clk   (clk),
        .we    (nw_en),
        .waddr (nw_addr),
        .wdata (nw_data),
        .re    (nr_en),
        .raddr (nr_addr),
        .rdata (nr_data)
    );

    hufd_ram #(.DEPTH(STACK_DEPTH), .WIDTH(AW)) u_stack_ram (
        .clk   (clk),
        .we    (sw_en),
        .waddr (sw_addr),
        .wdata (sw_data),
        .re    (sr_en),
        .raddr (sr_addr),
        .rdata (sr_data)
    );

    assign out_free = !out_valid_reg || out_ch.ready;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign terminal = (phase_reg == PH_DONE) || (phase_reg == PH_ERROR);
    assign in_ready = (ctl_reg == CTL_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg        <= CTL_IDLE;
            phase_reg      <= PH_TREE_NODE;
            count_reg      <= '0;
            sp_reg         <= '0;
            cur_idx_reg    <= '0;
            bits_reg       <= '0;
            len_reg        <= '0;
            chunk_reg      <= '0;
            acc_reg        <= '0;
            hdr_reg        <= '0;
            small_reg      <= 1'b0;
            left_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ctl_reg        <= ctl_next;
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            sp_reg         <= sp_next;
            cur_idx_reg    <= cur_idx_next;
            bits_reg       <= bits_next;
            len_reg        <= len_next;
            chunk_reg      <= chunk_next;
            acc_reg        <= acc_next;
            hdr_reg        <= hdr_next;
            small_reg      <= small_next;
            left_reg       <= left_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        fin_reg      <= fin_next;
        cur_reg      <= cur_next;
        root_reg     <= root_next;
        shift_reg    <= shift_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        logic [31:0]    shift_new;
        logic [31:0]    v;
        logic [NCW-1:0] nx;
        logic [SPW-1:0] sp_dec;
        logic [CHW-1:0] chunk_dec;
        logic [HW-1:0]  hdr_dec;
        logic [5:0]     bits_dec;
        logic           bit_in;
        ctl_t           after_bit;

        ctl_next        = ctl_reg;
        phase_next      = phase_reg;
        byte_next       = byte_reg;
        fin_next        = fin_reg;
        left_next       = left_reg;
        count_next      = count_reg;
        sp_next         = sp_reg;
        cur_idx_next    = cur_idx_reg;
        cur_next        = cur_reg;
        root_next       = root_reg;
        shift_next      = shift_reg;
        bits_next       = bits_reg;
        len_next        = len_reg;
        chunk_next      = chunk_reg;
        acc_next        = acc_reg;
        hdr_next        = hdr_reg;
        small_next      = small_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        nw_en           = 1'b0;
        nw_addr         = '0;
        nw_data         = '0;
        nr_en           = 1'b0;
        nr_addr         = '0;
        sw_en           = 1'b0;
        sw_addr         = '0;
        sw_data         = '0;
        sr_en           = 1'b0;
        emit            = 1'b0;
        emit_res        = '0;

        bit_in    = byte_reg[7];
        shift_new = {shift_reg[30:0], bit_in};
        v         = sym_align(shift_new, len_reg);
        sp_dec    = sp_reg - 1'b1;
        sr_addr   = sp_dec[SW-1:0];
        chunk_dec = chunk_reg - 1'b1;
        hdr_dec   = hdr_reg - 1'b1;
        bits_dec  = bits_reg - 1'b1;
        nx        = bit_in ? cur_reg.data[NCW-1:0] : cur_idx_reg + 1'b1;
        after_bit = (left_reg == 4'd1) ? CTL_END : CTL_BIT;

        case (ctl_reg)
            CTL_IDLE:
            begin
                if (in_ch.valid)
                begin
                    byte_next = in_ch.in_byte;
                    fin_next  = in_ch.final_byte;
                    left_next = 4'd8;
                    if (!terminal)
                    begin
                        ctl_next = CTL_BIT;
                    end
                end
            end
            CTL_BIT:
            begin
                if (emit_ok)
                begin
                    byte_next = {byte_reg[6:0], 1'b0};
                    left_next = left_reg - 1'b1;
                    ctl_next  = after_bit;
                    case (phase_reg)
                        PH_TREE_NODE:
                        begin
                            if (count_reg >= NCW'(MAX_NODES))
                            begin
                                emit = 1'b1;
                                emit_res.kind = KIND_ERROR;
                                phase_next = PH_ERROR;
                                ctl_next = CTL_END;
                            end
                            else if (!bit_in)
                            begin
                                if (sp_reg >= SPW'(STACK_DEPTH))
                                begin
                                    emit = 1'b1;
                                    emit_res.kind = KIND_ERROR;
                                    phase_next = PH_ERROR;
                                    ctl_next = CTL_END;
                                end
                                else
                                begin
                                    count_next = count_reg + 1'b1;
                                    nw_en   = 1'b1;
                                    nw_addr = count_reg[AW-1:0];
                                    nw_data = '0;
                                    sw_en   = 1'b1;
                                    sw_addr = sp_reg[SW-1:0];
                                    sw_data = count_reg[AW-1:0];
                                    sp_next = sp_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                count_next   = count_reg + 1'b1;
                                cur_idx_next = count_reg;
                                shift_next   = '0;
                                len_next     = '0;
                                bits_next    = 6'd6;
                                phase_next   = PH_TREE_SYM;
                            end
                        end
                        PH_TREE_SYM:
                        begin
                            shift_next = shift_new;
                            bits_next  = bits_dec;
                            if (bits_dec == '0)
                            begin
                                if (len_reg != '0)
                                begin
                                    if (!sym_ok(v, len_reg))
                                    begin
                                        emit = 1'b1;
                                        emit_res.kind = KIND_ERROR;
                                        phase_next = PH_ERROR;
                                        ctl_next = CTL_END;
                                    end
                                    else
                                    begin
                                        nw_en   = 1'b1;
                                        nw_addr = cur_idx_reg[AW-1:0];
                                        nw_data = '{leaf: 1'b1, len: len_reg, data: v};
                                        if (sp_reg == '0)
                                        begin
                                            phase_next   = PH_HEADER;
                                            cur_idx_next = '0;
                                        end
                                        else
                                        begin
                                            sp_next    = sp_dec;
                                            sr_en      = 1'b1;
                                            phase_next = PH_TREE_NODE;
                                            ctl_next   = CTL_POP;
                                        end
                                    end
                                end
                                else if (!shift_new[5])
                                begin
                                    len_next  = 3'd1;
                                    bits_next = 6'd2;
                                end
                                else if (shift_new[5:3] == 3'b110)
                                begin
                                    len_next  = 3'd2;
                                    bits_next = 6'd10;
                                end
                                else if (shift_new[5:2] == 4'b1110)
                                begin
                                    len_next  = 3'd3;
                                    bits_next = 6'd18;
                                end
                                else if (shift_new[5:1] == 5'b11110)
                                begin
                                    len_next  = 3'd4;
                                    bits_next = 6'd26;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                    emit_res.kind = KIND_ERROR;
                                    phase_next = PH_ERROR;
                                    ctl_next = CTL_END;
                                end
                            end
                        end
                        PH_HEADER:
                        begin
                            if (bit_in)
                            begin
                                small_next = 1'b0;
                                chunk_next = CHW'(BIG_CHUNK);
                                if (root_reg.leaf)
                                begin
                                    emit = 1'b1;
                                    emit_res = '{kind: KIND_SYMBOL, value: root_reg.data,
                                                 length: root_reg.len, rep: BIG_REP};
                                end
                                else
                                begin
                                    cur_idx_next = '0;
                                    cur_next     = root_reg;
                                    phase_next   = PH_DECODE;
                                end
                            end
                            else
                            begin
                                acc_next   = '0;
                                hdr_next   = HW'(COUNT_BITS);
                                phase_next = PH_COUNT;
                            end
                        end
                        PH_COUNT:
                        begin
                            acc_next = COUNT_BITS'({acc_reg, bit_in});
                            hdr_next = hdr_dec;
                            if (hdr_dec == '0)
                            begin
                                if (acc_next == '0)
                                begin
                                    emit = 1'b1;
                                    emit_res.kind = KIND_DONE;
                                    phase_next = PH_DONE;
                                    ctl_next = CTL_END;
                                end
                                else if (root_reg.leaf)
                                begin
                                    emit = 1'b1;
                                    emit_res = '{kind: KIND_SYMBOL, value: root_reg.data,
                                                 length: root_reg.len, rep: 13'(acc_next)};
                                    ctl_next = CTL_EMIT_DONE;
                                end
                                else
                                begin
                                    chunk_next   = CHW'(acc_next);
                                    small_next   = 1'b1;
                                    cur_idx_next = '0;
                                    cur_next     = root_reg;
                                    phase_next   = PH_DECODE;
                                end
                            end
                        end
                        PH_DECODE:
                        begin
                            if (nx >= NCW'(MAX_NODES))
                            begin
                                emit = 1'b1;
                                emit_res.kind = KIND_ERROR;
                                phase_next = PH_ERROR;
                                ctl_next = CTL_END;
                            end
                            else
                            begin
                                cur_idx_next = nx;
                                nr_en        = 1'b1;
                                nr_addr      = nx[AW-1:0];
                                ctl_next     = CTL_DEC_WAIT;
                            end
                        end
                        default:
                        begin
                            ctl_next = CTL_END;
                        end
                    endcase
                end
            end
            CTL_POP:
            begin
                nw_en    = 1'b1;
                nw_addr  = sr_data;
                nw_data  = '{leaf: 1'b0, len: 3'd0, data: 32'(count_reg)};
                ctl_next = (left_reg == '0) ? CTL_END : CTL_BIT;
            end
            CTL_DEC_WAIT:
            begin
                if (!nr_data.leaf)
                begin
                    cur_next = nr_data;
                    ctl_next = (left_reg == '0) ? CTL_END : CTL_BIT;
                end
                else if (emit_ok)
                begin
                    emit = 1'b1;
                    emit_res = '{kind: KIND_SYMBOL, value: nr_data.data,
                                 length: nr_data.len, rep: 13'd1};
                    cur_idx_next = '0;
                    cur_next     = root_reg;
                    chunk_next   = chunk_dec;
                    ctl_next     = (left_reg == '0) ? CTL_END : CTL_BIT;
                    if (chunk_dec == '0)
                    begin
                        if (small_reg)
                        begin
                            ctl_next = CTL_EMIT_DONE;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
            end
            CTL_EMIT_DONE:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    emit_res.kind = KIND_DONE;
                    phase_next = PH_DONE;
                    ctl_next = CTL_END;
                end
            end
            CTL_END:
            begin
                if (fin_reg && !terminal)
                begin
                    if (emit_ok)
                    begin
                        emit = 1'b1;
                        emit_res.kind = KIND_ERROR;
                        phase_next = PH_ERROR;
                    end
                end
                else
                begin
                    ctl_next = CTL_FLUSH;
                end
            end
            CTL_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    ctl_next = CTL_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    ctl_next        = CTL_IDLE;
                end
            end
            default:
            begin
                ctl_next = CTL_IDLE;
            end
        endcase

        // a new result pushes the held one out, marked as not last
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = emit_res;
        end

        if (nw_en && nw_addr == '0)
        begin
            root_next = nw_data;
        end
    end

    assign in_ch.ready          = in_ready;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.kind          = out_reg.kind;
    assign out_ch.symbol_value  = out_reg.value;
    assign out_ch.symbol_length = out_reg.length;
    assign out_ch.repeat_count  = out_reg.rep;
    assign out_ch.last_of_item  = out_last_reg;

    `ASSERT_SAME(a_idle_no_hold, ctl_reg == CTL_IDLE, !pend_valid_reg)
    `ASSERT_SAME(a_stack_bound, 1'b1, sp_reg <= SPW'(STACK_DEPTH))
    `ASSERT_SAME(a_emit_room, emit && pend_valid_reg, out_free)
    `ASSERT_NEXT(a_drop_after_end, in_ch.valid && in_ready && terminal, ctl_reg == CTL_IDLE)

endmodule
`default_nettype wire
